// ----- design/src_pkg.sv -----
// Shared constants and helpers for the signed radix conversion unit.
// No dependencies; imported by src_divider and signed_radix_conversion_unit.
`default_nettype none

package src_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned MEM_AW     = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(65);
  localparam logic [RADIX_W-1:0] DEC_MAX    = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] DEC_BASE   = RADIX_W'(10);

  // Maps a digit value to its ASCII code: 0-9 then A-Z.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] off;
    off = d - DEC_BASE;
    if (d <= DEC_MAX) begin
      return ASCII_ZERO + CHAR_W'(d);
    end
    return ASCII_A + CHAR_W'(off);
  endfunction

endpackage

`default_nettype wire

// ----- design/src_divider.sv -----
// Bit-serial restoring divider: 64-bit dividend by a 6-bit divisor,
// one quotient bit per cycle. Depends on src_pkg.
`default_nettype none

module src_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [src_pkg::DATA_W-1:0]   dividend,
  input  wire logic [src_pkg::RADIX_W-1:0]  divisor,
  output logic                              done,
  output logic [src_pkg::DATA_W-1:0]        quotient,
  output logic [src_pkg::RADIX_W-1:0]       remainder
);
  import src_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [DATA_W-1:0]    q_r, q_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   div_r;
  logic [RADIX_W:0]     trial;
  logic [RADIX_W:0]     diff;
  logic                 q_bit;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial   = {rem_r, q_r[DATA_W-1]};
    diff    = trial - {1'b0, div_r};
    q_bit   = (trial >= {1'b0, div_r});
    rem_nxt = q_bit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    q_nxt   = {q_r[DATA_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- design/signed_radix_conversion_unit.sv -----
// Top level of the signed radix conversion unit: sequencer, digit memory and
// output register. Depends on src_pkg and src_divider.
`default_nettype none

// Converts a signed 64-bit value to its digits in a radix from 2 to 36 (radix
// codes below 2 act as 2, above 36 as 36) and returns one transfer per digit,
// most significant first, as an ASCII code with the input's sign and a last
// flag on the final digit. Zero gives a single '0'. The input is taken only
// while the unit is idle. Each digit costs one pass of the shared bit-serial
// divider plus sequencing (divider start and result capture), and each
// emitted digit passes through a memory read, then an output register load,
// and waits there while the output is stalled.
module signed_radix_conversion_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [src_pkg::DATA_W-1:0]   in_value,
  input  wire logic [src_pkg::RADIX_W-1:0]  in_radix,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [src_pkg::CHAR_W-1:0]        out_char_code,
  output logic                              out_is_negative,
  output logic                              out_last
);
  import src_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_READ  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MEM_AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    mag_r;
  logic [RADIX_W-1:0]   radix_r;
  logic                 neg_r;
  logic [CHAR_W-1:0]    char_r;
  logic                 last_r;
  logic                 neg_out_r;

  logic [RADIX_W-1:0]   digit_mem [MAX_DIGITS];
  logic [RADIX_W-1:0]   mem_q_r;

  logic                 in_xfer;
  logic                 div_start;
  logic                 div_done;
  logic [DATA_W-1:0]    div_quot;
  logic [RADIX_W-1:0]   div_rem;
  logic                 load_out;
  logic [RADIX_W-1:0]   radix_clamped;
  logic                 more_digits;

  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    radix_clamped = in_radix;
    if (in_radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end
  end

  // Keep dividing while the quotient is nonzero and the store has room.
  assign more_digits = (div_quot != '0) && (count_r + CNT_W'(1) < CNT_W'(MAX_DIGITS));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    load_out      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          count_nxt = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          count_nxt = count_r + CNT_W'(1);
          if (more_digits) begin
            state_nxt = S_START;
          end else begin
            rd_idx_nxt = count_r[MEM_AW-1:0];
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (rd_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - MEM_AW'(1);
            state_nxt  = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operand registers; the magnitude of the most negative value is 2^63 unsigned.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r   <= in_value[DATA_W-1] ? (~in_value + DATA_W'(1)) : in_value;
      neg_r   <= in_value[DATA_W-1];
      radix_r <= radix_clamped;
    end else if (state_r == S_WAIT && div_done) begin
      mag_r <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && div_done) begin
      digit_mem[count_r[MEM_AW-1:0]] <= div_rem;
    end
    mem_q_r <= digit_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      char_r    <= digit_to_ascii(mem_q_r);
      neg_out_r <= neg_r;
      last_r    <= (rd_idx_r == '0);
    end
  end

  src_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char_code   = char_r;
  assign out_is_negative = neg_out_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire
